// ===== hdl/mvm_pkg.sv =====
package mvm_pkg;

   // field widths of the channels
   localparam int CFG_W     = 5;
   localparam int FUNC_W    = 2;
   localparam int IDX_W     = 4;
   localparam int VALUE_W   = 16;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int DOT_W     = 32;
   localparam int CSR_IDX_W = 1;

   // exact sum of up to 31 products of full-scale q8.8 values
   localparam int ACC_W = PROD_W + 6;

   localparam int DEF_MAX_ROWS    = 16;
   localparam int DEF_MAX_COLUMNS = 16;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   // function codes of an input word
   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_VECTOR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_ERROR
   } state_type;

endpackage

// ===== hdl/mvm_req_if.sv =====
interface mvm_req_if import mvm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic [IDX_W-1:0]          row_index;
   logic [IDX_W-1:0]          column_index;
   logic signed [VALUE_W-1:0] value;
   logic                      last_element;

   modport source (
      output valid, func, row_index, column_index, value, last_element,
      input  ready
   );
   modport sink (
      input  valid, func, row_index, column_index, value, last_element,
      output ready
   );
endinterface

// ===== hdl/mvm_rsp_if.sv =====
interface mvm_rsp_if import mvm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [DOT_W-1:0] dot_product;
   logic [IDX_W-1:0]        result_row;
   logic                    last_result;
   logic                    length_error;

   modport source (
      output valid, dot_product, result_row, last_result, length_error,
      input  ready
   );
   modport sink (
      input  valid, dot_product, result_row, last_result, length_error,
      output ready
   );
endinterface

// ===== hdl/mvm_csr_if.sv =====
interface mvm_csr_if import mvm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== hdl/matrix_vector_multiply.sv =====
// matrix-vector multiplier over a q8.8 matrix store
// req_bus: one word per handshake. func selects an entry write (row_index,
//   column_index, value), a vector element (value, last_element) or a clear
//   of the whole matrix store.
// rsp_bus: one word per active row, dot_product in q16.16 saturated to 32 bits,
//   last_result on the final row; a vector longer than columns_in_use gives
//   a single word with length_error set instead
// csr_bus: index 0 rows_in_use, index 1 columns_in_use, always ready,
//   write only while the block is idle
// sequencing: after the last element the block walks rows x elements through one
//   shared multiplier and accumulator. each row issues its n memory reads, then
//   the read, multiply and add stages drain, and req_bus.ready is back once the
//   last row result is loaded
// reset and clear: a clearing pass zeroes one matrix entry per cycle, all
//   MAX_ROWS * MAX_COLUMNS entries (256 by default), with req_bus.ready low
// stall: results sit in an output register; a row result waits there until
//   taken, and the sequencer holds its next row meanwhile. once the last
//   result is loaded, new words are accepted even while it still waits
module matrix_vector_multiply import mvm_pkg::*; #(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input logic        clock,
   input logic        reset,
   mvm_req_if.sink    req_bus,
   mvm_rsp_if.source  rsp_bus,
   mvm_csr_if.sink    csr_bus
);

   localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VAW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int LIN_W = 2 * CFG_W + 1;

   // configuration
   logic [CFG_W-1:0] rows_cfg_ff, cols_cfg_ff;
   logic [CFG_W-1:0] rows_eff, cols_eff;

   // sequencer
   state_type        state_ff, state_in;
   logic [MAW-1:0]   clr_addr_ff, clr_addr_in;
   logic [CFG_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CFG_W-1:0] row_ff, row_in;
   logic [CFG_W-1:0] col_ff, col_in;

   // stores
   logic signed [VALUE_W-1:0] mat_mem [DEPTH];
   logic signed [VALUE_W-1:0] vec_mem [MAX_COLUMNS];
   logic                      mat_we, vec_we;
   logic [MAW-1:0]            mat_wa, issue_addr, entry_addr;
   logic signed [VALUE_W-1:0] mat_wd;
   logic [LIN_W-1:0]          entry_lin, issue_lin;

   // datapath stages
   logic                      issue;
   logic signed [VALUE_W-1:0] m_rd_ff, v_rd_ff;
   logic                      p1_vld_ff, p1_first_ff, p1_last_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      p2_vld_ff, p2_first_ff, p2_last_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      done_ff;
   logic signed [DOT_W-1:0]   sat_dot;

   // output register
   logic                    rsp_vld_ff;
   logic signed [DOT_W-1:0] dot_ff;
   logic [IDX_W-1:0]        row_out_ff;
   logic                    last_ff, err_ff;
   logic                    load_rsp, load_err, out_free;

   logic req_fire, row_ok, col_ok, store_ok, ovf_next, last_row, last_col;

   // registers clamp 0 to 1 and large values to the store size
   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_eff = CFG_W'(1);
      end else if (int'(rows_cfg_ff) > MAX_ROWS) begin
         rows_eff = CFG_W'(MAX_ROWS);
      end else begin
         rows_eff = rows_cfg_ff;
      end
      if (cols_cfg_ff == '0) begin
         cols_eff = CFG_W'(1);
      end else if (int'(cols_cfg_ff) > MAX_COLUMNS) begin
         cols_eff = CFG_W'(MAX_COLUMNS);
      end else begin
         cols_eff = cols_cfg_ff;
      end
   end

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= CFG_RESET;
         cols_cfg_ff <= CFG_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ROWS: rows_cfg_ff <= csr_bus.data;
            CSR_COLS: cols_cfg_ff <= csr_bus.data;
            default:  ;
         endcase
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // row-major layout with the active column count as stride
   assign entry_lin  = LIN_W'(req_bus.row_index) * LIN_W'(cols_eff)
                     + LIN_W'(req_bus.column_index);
   assign entry_addr = MAW'(entry_lin);
   assign issue_lin  = LIN_W'(row_ff) * LIN_W'(cols_eff) + LIN_W'(col_ff);
   assign issue_addr = MAW'(issue_lin);

   assign row_ok   = int'(req_bus.row_index) < MAX_ROWS;
   assign col_ok   = CFG_W'(req_bus.column_index) < cols_eff;
   assign store_ok = (count_ff < cols_eff) && (int'(count_ff) < MAX_COLUMNS);
   assign ovf_next = ovf_ff || !store_ok;
   assign last_row = (row_ff == rows_eff - CFG_W'(1));
   assign last_col = (col_ff == count_ff - CFG_W'(1));
   assign out_free = !rsp_vld_ff || rsp_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == MAW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.func)
                  FUNC_CLEAR: state_in = ST_CLEAR;
                  FUNC_VECTOR: begin
                     if (req_bus.last_element) state_in = ovf_next ? ST_ERROR : ST_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            if (last_col) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (done_ff && out_free) state_in = last_row ? ST_IDLE : ST_ISSUE;
         end
         ST_ERROR: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      mat_we      = 1'b0;
      mat_wa      = entry_addr;
      mat_wd      = req_bus.value;
      vec_we      = 1'b0;
      issue       = 1'b0;
      load_rsp    = 1'b0;
      load_err    = 1'b0;
      clr_addr_in = clr_addr_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      case (state_ff)
         ST_CLEAR: begin
            mat_we      = 1'b1;
            mat_wa      = clr_addr_ff;
            mat_wd      = '0;
            clr_addr_in = clr_addr_ff + MAW'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.func)
                  FUNC_WRITE: mat_we = row_ok && col_ok;
                  FUNC_VECTOR: begin
                     vec_we = store_ok;
                     if (store_ok) count_in = count_ff + CFG_W'(1);
                     ovf_in = ovf_next;
                     if (req_bus.last_element) begin
                        row_in = '0;
                        col_in = '0;
                     end
                  end
                  FUNC_CLEAR: clr_addr_in = '0;
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            issue  = 1'b1;
            col_in = col_ff + CFG_W'(1);
         end
         ST_DRAIN: begin
            if (done_ff && out_free) begin
               load_rsp = 1'b1;
               if (last_row) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  row_in = row_ff + CFG_W'(1);
                  col_in = '0;
               end
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               load_err = 1'b1;
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
   end

   // matrix store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[mat_wa] <= mat_wd;
   end

   always_ff @(posedge clock) begin
      m_rd_ff <= mat_mem[issue_addr];
   end

   // vector store
   always_ff @(posedge clock) begin
      if (vec_we) vec_mem[VAW'(count_ff)] <= req_bus.value;
   end

   always_ff @(posedge clock) begin
      v_rd_ff <= vec_mem[VAW'(col_ff)];
   end

   // read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         p1_vld_ff <= issue;
         p2_vld_ff <= p1_vld_ff;
         if (load_rsp) begin
            done_ff <= 1'b0;
         end else if (p2_vld_ff && p2_last_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p1_first_ff <= (col_ff == '0);
      p1_last_ff  <= last_col;
      p2_first_ff <= p1_first_ff;
      p2_last_ff  <= p1_last_ff;
      prod_ff     <= m_rd_ff * v_rd_ff;
      if (p2_vld_ff) begin
         acc_ff <= p2_first_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      end
   end

   // saturate when the 32-bit sign bit and the bits above it are not all equal
   always_comb begin
      if (&acc_ff[ACC_W-1:DOT_W-1] || ~|acc_ff[ACC_W-1:DOT_W-1]) begin
         sat_dot = acc_ff[DOT_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_dot = {1'b1, {(DOT_W-1){1'b0}}};
      end else begin
         sat_dot = {1'b0, {(DOT_W-1){1'b1}}};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (load_rsp || load_err) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         dot_ff     <= sat_dot;
         row_out_ff <= IDX_W'(row_ff);
         last_ff    <= last_row;
         err_ff     <= 1'b0;
      end else if (load_err) begin
         dot_ff     <= '0;
         row_out_ff <= '0;
         last_ff    <= 1'b1;
         err_ff     <= 1'b1;
      end
   end

   assign rsp_bus.valid        = rsp_vld_ff;
   assign rsp_bus.dot_product  = dot_ff;
   assign rsp_bus.result_row   = row_out_ff;
   assign rsp_bus.last_result  = last_ff;
   assign rsp_bus.length_error = err_ff;

endmodule

// ===== hdl/mvm_checker.sv =====
module mvm_checker import mvm_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [DOT_W-1:0] rsp_dot_product,
   input logic [IDX_W-1:0]        rsp_result_row,
   input logic                    rsp_last_result,
   input logic                    rsp_length_error
);

   // clearing pass follows reset, nothing shown yet
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("busy or result right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dot_product) && $stable(rsp_result_row)
         && $stable(rsp_last_result) && $stable(rsp_length_error))
      else $error("stalled result word changed");

   // an error word stands alone and carries no product
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |->
         rsp_last_result && rsp_dot_product == '0 && rsp_result_row == '0)
      else $error("malformed length error word");

   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> !rsp_length_error)
      else $error("length error inside a run of row results");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_dot_product  (rsp_bus.dot_product),
   .rsp_result_row   (rsp_bus.result_row),
   .rsp_last_result  (rsp_bus.last_result),
   .rsp_length_error (rsp_bus.length_error)
);

// ===== verif/matrix_vector_multiply_tb.sv =====
`timescale 1ns / 100ps

module matrix_vector_multiply_tb;
   import mvm_pkg::*;

   // func 3 has no meaning in the block, it must be dropped silently
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int STORE_DEPTH      = DEF_MAX_ROWS * DEF_MAX_COLUMNS;
   // sized for a clearing pass over 256 entries and a full multiply of 16 rows
   localparam int SETTLE_CYCLES    = 400;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int CYCLE_LIMIT      = 300000;
   localparam int NUM_DIRECTED     = 24;
   localparam int NUM_PHASES       = 6;
   localparam int RANDOM_PER_PHASE = 10;

   localparam longint DOT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint DOT_MIN = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [IDX_W-1:0]          row_index;
      logic [IDX_W-1:0]          column_index;
      logic signed [VALUE_W-1:0] value;
      logic                      last_element;
   } word_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] dot_product;
      logic [IDX_W-1:0]        result_row;
      logic                    last_result;
      logic                    length_error;
   } dot_result_type;

   // where the expected words of a directed row come from
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_ZEROS,
      CHECK_LENGTH_ERROR
   } check_type;

   typedef enum logic {
      STEP_WORD,
      STEP_CONFIG
   } step_type;

   typedef struct packed {
      step_type           kind;
      logic [FUNC_W-1:0]  func;
      logic [IDX_W-1:0]   row_index;
      logic [IDX_W-1:0]   column_index;
      logic [VALUE_W-1:0] value;
      logic               last_element;
      check_type          check_kind;
      logic [CFG_W-1:0]   rows_cfg;
      logic [CFG_W-1:0]   cols_cfg;
   } directed_step_type;

   logic clock;
   logic reset;

   mvm_req_if req_bus ();
   mvm_rsp_if rsp_bus ();
   mvm_csr_if csr_bus ();

   matrix_vector_multiply u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predicted state of the block
   logic signed [VALUE_W-1:0] matrix_q88 [STORE_DEPTH];
   logic signed [VALUE_W-1:0] vector_q88 [DEF_MAX_COLUMNS];
   int unsigned               elements_held;
   bit                        vector_overrun;
   logic [CFG_W-1:0]          rows_setting = CFG_RESET;
   logic [CFG_W-1:0]          cols_setting = CFG_RESET;

   // dot product words still owed by the block, oldest first
   dot_result_type expected_dots [$];

   int unsigned mismatches;
   int unsigned busy_words;
   int unsigned results_checked;
   int unsigned length_errors_seen;
   int unsigned settings_applied;
   int unsigned cycle_count;

   bit quiet_tail;      // no idling on either side near the end
   bit hold_requested;  // asks the long receiver hold-off
   bit rsp_held;

   // settings per phase: over-range, one, full size and small; phase 4 is drawn at random
   logic [CFG_W-1:0] phase_rows [NUM_PHASES] = '{5'd31, 5'd1, 5'd16, 5'd17, 5'd0, 5'd16};
   logic [CFG_W-1:0] phase_cols [NUM_PHASES] = '{5'd31, 5'd16, 5'd1, 5'd3, 5'd0, 5'd16};

   // directed part, reset settings are 16 rows by 16 columns
   directed_step_type directed_steps [NUM_DIRECTED] = '{
      // matrix is clear after reset: every row gives zero
      '{STEP_WORD, FUNC_VECTOR, 4'd0, 4'd0, 16'h7FFF, 1'b1, CHECK_ZEROS, 5'd0, 5'd0},
      // row 0 all most-negative, row 1 all most-positive
      '{STEP_WORD, FUNC_WRITE, 4'd0, 4'd0, 16'h8000, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_WRITE, 4'd0, 4'd1, 16'h8000, 1'b1, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_WRITE, 4'd0, 4'd2, 16'h8000, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_WRITE, 4'd1, 4'd0, 16'h7FFF, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_WRITE, 4'd1, 4'd1, 16'h7FFF, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_WRITE, 4'd1, 4'd2, 16'h7FFF, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_WRITE, 4'd15, 4'd15, 16'h0180, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      // unused func with every field set, dropped
      '{STEP_WORD, FUNC_UNUSED, 4'd15, 4'd15, 16'hFFFF, 1'b1, CHECK_MODEL, 5'd0, 5'd0},
      // three full-scale products per row saturate high on row 0, low on row 1
      '{STEP_WORD, FUNC_VECTOR, 4'd15, 4'd15, 16'h8000, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_VECTOR, 4'd0, 4'd0, 16'h8000, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_VECTOR, 4'd0, 4'd0, 16'h8000, 1'b1, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_CLEAR, 4'd0, 4'd0, 16'h0000, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_VECTOR, 4'd0, 4'd0, 16'h4000, 1'b1, CHECK_ZEROS, 5'd0, 5'd0},
      // zero settings count as one row by one column
      '{STEP_CONFIG, FUNC_WRITE, 4'd0, 4'd0, 16'h0000, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_WRITE, 4'd0, 4'd0, 16'h0200, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      // column past columns_in_use, write ignored
      '{STEP_WORD, FUNC_WRITE, 4'd0, 4'd1, 16'h1234, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      // stored but row not active
      '{STEP_WORD, FUNC_WRITE, 4'd2, 4'd0, 16'h0300, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      // two elements into one column: length error
      '{STEP_WORD, FUNC_VECTOR, 4'd0, 4'd0, 16'h0100, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_VECTOR, 4'd0, 4'd0, 16'h0300, 1'b1, CHECK_LENGTH_ERROR, 5'd0, 5'd0},
      // run state cleared after the error
      '{STEP_WORD, FUNC_VECTOR, 4'd0, 4'd0, 16'h0100, 1'b1, CHECK_MODEL, 5'd0, 5'd0},
      // clear inside a run leaves the run alone
      '{STEP_WORD, FUNC_VECTOR, 4'd0, 4'd0, 16'h0001, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_CLEAR, 4'd0, 4'd0, 16'h0000, 1'b0, CHECK_MODEL, 5'd0, 5'd0},
      '{STEP_WORD, FUNC_VECTOR, 4'd0, 4'd0, 16'hFFFF, 1'b1, CHECK_LENGTH_ERROR, 5'd0, 5'd0}
   };

   function automatic int unsigned clamp_setting(input logic [CFG_W-1:0] v,
                                                 input int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // mostly random, with a fair share of extremes and small values
   function automatic logic signed [VALUE_W-1:0] pick_q88();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return VALUE_W'($signed($urandom_range(0, 1024)) - 512);
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // updates the predicted state for one word, returns the words it causes
   function automatic void predict_dot_products(input word_type w,
                                                output dot_result_type produced [$]);
      int unsigned rows_n;
      int unsigned cols_n;
      longint      acc;
      produced = {};
      rows_n = clamp_setting(rows_setting, DEF_MAX_ROWS);
      cols_n = clamp_setting(cols_setting, DEF_MAX_COLUMNS);
      case (w.func)
         FUNC_WRITE: begin
            if (w.column_index < cols_n)
               matrix_q88[w.row_index * cols_n + w.column_index] = w.value;
         end
         FUNC_CLEAR: begin
            foreach (matrix_q88[i]) matrix_q88[i] = '0;
         end
         FUNC_VECTOR: begin
            if (elements_held < cols_n) begin
               vector_q88[elements_held] = w.value;
               elements_held++;
            end else begin
               vector_overrun = 1'b1;
            end
            if (w.last_element) begin
               if (vector_overrun) begin
                  produced.push_back('{dot_product: '0, result_row: '0,
                                       last_result: 1'b1, length_error: 1'b1});
               end else begin
                  for (int r = 0; r < rows_n; r++) begin
                     acc = 0;
                     for (int i = 0; i < elements_held; i++)
                        acc += longint'(matrix_q88[r * cols_n + i]) * longint'(vector_q88[i]);
                     if (acc > DOT_MAX) acc = DOT_MAX;
                     if (acc < DOT_MIN) acc = DOT_MIN;
                     produced.push_back('{dot_product: DOT_W'(acc), result_row: IDX_W'(r),
                                          last_result: (r == rows_n - 1), length_error: 1'b0});
                  end
               end
               elements_held  = 0;
               vector_overrun = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   // offers one word, waits for the handshake, then books what it should cause
   task automatic send_word(input word_type w, input check_type check_kind);
      dot_result_type produced [$];
      int unsigned    rows_n;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= w.func;
      req_bus.row_index    <= w.row_index;
      req_bus.column_index <= w.column_index;
      req_bus.value        <= w.value;
      req_bus.last_element <= w.last_element;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      rows_n = clamp_setting(rows_setting, DEF_MAX_ROWS);
      predict_dot_products(w, produced);
      if (w.func != FUNC_UNUSED) busy_words++;
      case (check_kind)
         // all-zero matrix: one zero word per active row
         CHECK_ZEROS: begin
            for (int r = 0; r < rows_n; r++)
               expected_dots.push_back('{dot_product: '0, result_row: IDX_W'(r),
                                          last_result: (r == rows_n - 1), length_error: 1'b0});
         end
         CHECK_LENGTH_ERROR: begin
            expected_dots.push_back('{dot_product: '0, result_row: '0,
                                       last_result: 1'b1, length_error: 1'b1});
         end
         default: begin
            foreach (produced[i]) expected_dots.push_back(produced[i]);
         end
      endcase
   endtask

   // all results in, then room for a multiply or clearing pass still running
   task automatic wait_block_idle();
      req_bus.valid <= 1'b0;
      while (expected_dots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CFG_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (index == CSR_ROWS) rows_setting = data;
      else cols_setting = data;
   endtask

   task automatic apply_config(input logic [CFG_W-1:0] rows_cfg,
                               input logic [CFG_W-1:0] cols_cfg);
      wait_block_idle();
      write_register(CSR_ROWS, rows_cfg);
      write_register(CSR_COLS, cols_cfg);
      csr_bus.valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic check_result(input dot_result_type got);
      dot_result_type want;
      results_checked++;
      if (got.length_error) length_errors_seen++;
      if (expected_dots.size() == 0) begin
         $error("result word with nothing pending: row %0d dot_product %0d",
                got.result_row, got.dot_product);
         mismatches++;
         return;
      end
      want = expected_dots.pop_front();
      if (got.dot_product !== want.dot_product) begin
         $error("dot_product expected %0d actual %0d", want.dot_product, got.dot_product);
         mismatches++;
      end
      if (got.result_row !== want.result_row) begin
         $error("result_row expected %0d actual %0d", want.result_row, got.result_row);
         mismatches++;
      end
      if (got.last_result !== want.last_result) begin
         $error("last_result expected %0b actual %0b", want.last_result, got.last_result);
         mismatches++;
      end
      if (got.length_error !== want.length_error) begin
         $error("length_error expected %0b actual %0b", want.length_error, got.length_error);
         mismatches++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still pending",
                  cycle_count, expected_dots.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // long receiver hold-off, counted here so the sender keeps offering words
   initial begin : long_hold
      wait (hold_requested);
      @(posedge clock);
      rsp_held <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_held <= 1'b0;
   end

   // result side: check on each handshake, stall in random bursts
   initial begin : result_sink
      int unsigned stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            check_result('{dot_product: rsp_bus.dot_product, result_row: rsp_bus.result_row,
                           last_result: rsp_bus.last_result,
                           length_error: rsp_bus.length_error});
         if (rsp_held) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(1, 10) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      word_type    w;
      int unsigned cols_n;
      int unsigned run_len;
      int unsigned phase_goal;
      logic [CFG_W-1:0] rows_pick;
      logic [CFG_W-1:0] cols_pick;

      // every input known from time zero
      req_bus.valid        = 1'b0;
      req_bus.func         = FUNC_WRITE;
      req_bus.row_index    = '0;
      req_bus.column_index = '0;
      req_bus.value        = '0;
      req_bus.last_element = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_ROWS;
      csr_bus.data         = '0;
      foreach (matrix_q88[i]) matrix_q88[i] = '0;
      foreach (vector_q88[i]) vector_q88[i] = '0;
      elements_held  = 0;
      vector_overrun = 1'b0;

      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows, the first words wait out the clearing pass
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CONFIG) begin
            apply_config(directed_steps[i].rows_cfg, directed_steps[i].cols_cfg);
         end else begin
            w = '{func: directed_steps[i].func,
                  row_index: directed_steps[i].row_index,
                  column_index: directed_steps[i].column_index,
                  value: directed_steps[i].value,
                  last_element: directed_steps[i].last_element};
            send_word(w, directed_steps[i].check_kind);
         end
      end

      // random phases, one register setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         rows_pick = phase_rows[p];
         cols_pick = phase_cols[p];
         if (p == 4) begin
            rows_pick = CFG_W'($urandom_range(0, 31));
            cols_pick = CFG_W'($urandom_range(0, 31));
         end
         apply_config(rows_pick, cols_pick);
         // full size first phase: hold results off long enough to back up the input
         if (p == 0) hold_requested = 1'b1;
         if (p == NUM_PHASES - 1) quiet_tail <= 1'b1;
         cols_n     = clamp_setting(cols_setting, DEF_MAX_COLUMNS);
         phase_goal = busy_words + RANDOM_PER_PHASE;
         while (busy_words < phase_goal) begin
            // load some entries, now and then out of range
            repeat ($urandom_range(0, 5)) begin
               w              = word_type'(27'($urandom));
               w.func         = FUNC_WRITE;
               w.column_index = ($urandom_range(0, 7) == 0) ?
                                IDX_W'($urandom_range(0, 15)) :
                                IDX_W'($urandom_range(0, cols_n - 1));
               w.value        = pick_q88();
               send_word(w, CHECK_MODEL);
            end
            if ($urandom_range(0, 9) == 0) begin
               w      = word_type'(27'($urandom));
               w.func = FUNC_CLEAR;
               send_word(w, CHECK_MODEL);
            end
            // a vector run, sometimes too long for the columns in use
            run_len = ($urandom_range(0, 5) == 0) ? cols_n + $urandom_range(1, 3) :
                      $urandom_range(1, cols_n);
            for (int k = 0; k < run_len; k++) begin
               // noise: any func with random fields, may break the run early
               if ($urandom_range(0, 11) == 0) begin
                  w = word_type'(27'($urandom));
                  send_word(w, CHECK_MODEL);
               end
               w              = word_type'(27'($urandom));
               w.func         = FUNC_VECTOR;
               w.value        = pick_q88();
               w.last_element = (k == run_len - 1);
               send_word(w, CHECK_MODEL);
            end
         end
      end

      wait_block_idle();
      $display("run: %0d words to the block, %0d result words checked, %0d length errors",
               busy_words, results_checked, length_errors_seen);
      $display("run: %0d register settings incl. zero and over-range values",
               settings_applied);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/mvm_pkg.sv
hdl/mvm_req_if.sv
hdl/mvm_rsp_if.sv
hdl/mvm_csr_if.sv
hdl/matrix_vector_multiply.sv
hdl/mvm_checker.sv
verif/matrix_vector_multiply_tb.sv
